// ===== hdl/brlo_pkg.sv =====
// ----------------------------------------------------------------------------
// brlo_pkg: shared types, constants and helpers
// Constants, configuration record, step codes and rounding helpers for the
// resonant curve lowpass with op-amp soft clip.
// ----------------------------------------------------------------------------
package brlo_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int CFG_INDEX_W      = 4;
  localparam int CFG_DATA_W       = 30;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF_STEP   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACID_TRIM     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OVER_GAIN     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNDER_GAIN    = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MELTDOWN_MIX  = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_TRIM    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_TRIM   = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGHPASS_RATE = 4'd7;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] MIN_STEP  = 17'd7;
  localparam logic [29:0] ITRIM_MAX = 30'd655360000;

  localparam logic [16:0] RST_CUTOFF_STEP   = 17'd32768;
  localparam logic [16:0] RST_ACID_TRIM     = 17'd65280;
  localparam logic [16:0] RST_OVER_GAIN     = 17'd0;
  localparam logic [16:0] RST_UNDER_GAIN    = 17'd65536;
  localparam logic [16:0] RST_MELTDOWN_MIX  = 17'd0;
  localparam logic [29:0] RST_INPUT_TRIM    = 30'd6554;
  localparam logic [16:0] RST_OUTPUT_TRIM   = 17'd65536;
  localparam logic [15:0] RST_HIGHPASS_RATE = 16'd11576;

  // fixed 15.5 kHz lowpass biquad at 44.1 kHz, Q8.24
  localparam logic signed [33:0] LP_A0  = 34'sd9359901;
  localparam logic signed [33:0] LP_A1  = 34'sd18719802;
  localparam logic signed [33:0] LP_A2  = 34'sd9359901;
  localparam logic signed [33:0] LP_B1  = 34'sd13970094;
  localparam logic signed [33:0] LP_B2  = 34'sd6692294;
  localparam logic signed [33:0] CLIP_K = 34'sd11587;

  typedef struct packed {
    logic [16:0] cutoff_step;
    logic [16:0] acid_trim;
    logic [16:0] over_gain;
    logic [16:0] under_gain;
    logic [16:0] meltdown_mix;
    logic [29:0] input_trim;
    logic [16:0] output_trim;
    logic [15:0] highpass_rate;
  } cfg_t;

  typedef enum logic [5:0] {
    ST_SEG_MUL, ST_SEG_ACC, ST_MELT_A, ST_MELT_B, ST_MELT_PT,
    ST_PX_MUL, ST_PX, ST_PYY_MUL, ST_PXX_MUL, ST_W3_MUL,
    ST_W2_MUL, ST_W1_MUL, ST_W0_MUL, ST_MID3, ST_MID2,
    ST_MID1, ST_MID0, ST_MID, ST_UND, ST_OVR,
    ST_MIX, ST_TRIM, ST_DRIVE, ST_HP_MUL, ST_HP_LO, ST_HP_ACC,
    ST_HP_SUB, ST_BQ1_A0, ST_BQ1_A1, ST_BQ1_A2, ST_BQ1_B1,
    ST_BQ1_B2, ST_BQ1_OUT, ST_CLAMP, ST_SQ_MUL, ST_SQ,
    ST_Q4_MUL, ST_Q4, ST_Q5_MUL, ST_Q5, ST_CLIP_MUL,
    ST_CLIP, ST_BQ2_A0, ST_BQ2_A1, ST_BQ2_A2, ST_BQ2_B1,
    ST_BQ2_B2, ST_BQ2_OUT, ST_OTRIM_MUL, ST_OTRIM, ST_EMIT
  } step_t;

  typedef enum logic [1:0] {
    CS_IDLE = 2'b01,
    CS_RUN  = 2'b10
  } ctrl_state_t;

  typedef struct packed {
    logic  load;
    logic  exec;
    step_t step;
  } dp_cmd_t;

  // round half up, then arithmetic shift right
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v, input int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    if (v > 64'sd549755813887) return 40'sh7FFFFFFFFF;
    if (v < -64'sd549755813888) return 40'sh8000000000;
    return v[39:0];
  endfunction

endpackage

// ===== hdl/brlo_if.sv =====
// ----------------------------------------------------------------------------
// brlo_if: channel interfaces
// Sample input, sample output and configuration write channels.
// ----------------------------------------------------------------------------
interface brlo_in_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface brlo_out_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface brlo_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [29:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/brlo_cfg.sv =====
// ----------------------------------------------------------------------------
// brlo_cfg: configuration register file
// Holds the eight registers and presents them clamped to their legal ranges.
// ----------------------------------------------------------------------------
module brlo_cfg import brlo_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_valid,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output logic                   wr_ready,
  output cfg_t                   cfg
);

  cfg_t raw_r;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r.cutoff_step   <= RST_CUTOFF_STEP;
      raw_r.acid_trim     <= RST_ACID_TRIM;
      raw_r.over_gain     <= RST_OVER_GAIN;
      raw_r.under_gain    <= RST_UNDER_GAIN;
      raw_r.meltdown_mix  <= RST_MELTDOWN_MIX;
      raw_r.input_trim    <= RST_INPUT_TRIM;
      raw_r.output_trim   <= RST_OUTPUT_TRIM;
      raw_r.highpass_rate <= RST_HIGHPASS_RATE;
    end else if (wr_valid) begin
      unique case (wr_index)
        REG_CUTOFF_STEP:   raw_r.cutoff_step   <= wr_data[16:0];
        REG_ACID_TRIM:     raw_r.acid_trim     <= wr_data[16:0];
        REG_OVER_GAIN:     raw_r.over_gain     <= wr_data[16:0];
        REG_UNDER_GAIN:    raw_r.under_gain    <= wr_data[16:0];
        REG_MELTDOWN_MIX:  raw_r.meltdown_mix  <= wr_data[16:0];
        REG_INPUT_TRIM:    raw_r.input_trim    <= wr_data;
        REG_OUTPUT_TRIM:   raw_r.output_trim   <= wr_data[16:0];
        REG_HIGHPASS_RATE: raw_r.highpass_rate <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // clamp to legal ranges
  always_comb begin
    cfg = raw_r;
    if (raw_r.cutoff_step < MIN_STEP) cfg.cutoff_step = MIN_STEP;
    if (raw_r.cutoff_step > ONE_Q16)  cfg.cutoff_step = ONE_Q16;
    if (raw_r.acid_trim > ONE_Q16)    cfg.acid_trim = ONE_Q16;
    if (raw_r.over_gain > ONE_Q16)    cfg.over_gain = ONE_Q16;
    if (raw_r.under_gain > ONE_Q16)   cfg.under_gain = ONE_Q16;
    if (raw_r.meltdown_mix > ONE_Q16) cfg.meltdown_mix = ONE_Q16;
    if (raw_r.input_trim > ITRIM_MAX) cfg.input_trim = ITRIM_MAX;
    if (raw_r.output_trim > ONE_Q16)  cfg.output_trim = ONE_Q16;
  end

endmodule

// ===== hdl/brlo_ctrl.sv =====
// ----------------------------------------------------------------------------
// brlo_ctrl: sequencer
// Accepts one item, walks the datapath through its steps, owns output valid.
// ----------------------------------------------------------------------------
module brlo_ctrl import brlo_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  step_t       step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign in_ready  = (state_r == CS_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  assign cmd.load = in_ready && in_valid;
  assign cmd.step = step_r;
  // hold the final step until the output register can take the result
  assign cmd.exec = (state_r == CS_RUN) && ((step_r != ST_EMIT) || slot_free);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        if (cmd.load) begin
          state_nxt = CS_RUN;
          step_nxt  = ST_SEG_MUL;
        end
      end
      CS_RUN: begin
        if (cmd.exec) begin
          if (step_r == ST_EMIT) begin
            state_nxt     = CS_IDLE;
            out_valid_nxt = 1'b1;
          end else begin
            step_nxt = step_t'(step_r + 6'd1);
          end
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      step_r      <= ST_SEG_MUL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/brlo_dp.sv =====
// ----------------------------------------------------------------------------
// brlo_dp: datapath
// Filter state, scratch registers and one shared registered multiplier.
// ----------------------------------------------------------------------------
module brlo_dp import brlo_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dp_cmd_t                        cmd,
  input  cfg_t                           cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  localparam int UP = (SAMPLE_WIDTH >= 25) ? SAMPLE_WIDTH - 25 : 0;
  localparam int DN = (SAMPLE_WIDTH < 25) ? 25 - SAMPLE_WIDTH : 0;
  localparam logic signed [63:0] HALF32 = 64'sh80000000;
  localparam logic signed [63:0] OUT_HI = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_LO = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
  localparam logic signed [31:0] CLAMP_ONE = 32'sd16777216;

  // persistent filter state
  logic        [17:0] phase_r;
  logic signed [31:0] seg_r;
  logic signed [31:0] cp_r [4];
  logic signed [39:0] hs_r;
  logic signed [31:0] bq1_r [4];
  logic signed [31:0] bq2_r [4];

  // scratch
  logic               wrap_r;
  logic signed [31:0] x_r, v_r, mid_r, t_r;
  logic        [16:0] px_r, w3_r, w2_r, w1_r, w0_r;
  logic        [32:0] pyy_r, pxx_r;
  logic signed [63:0] p_r, acc_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [63:0] mul_prod;
  logic        [16:0] py;
  logic signed [40:0] hp_diff;
  logic               bank2;
  logic signed [31:0] h0, h1, h2, h3, y_nxt;
  logic signed [63:0] raw64, x64, v64, o64;
  logic signed [31:0] x_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_nxt;

  assign py    = ONE_Q16 - px_r;
  // highpass difference, multiplied in an upper and a lower half
  assign hp_diff = (41'(v_r) <<< 8) - 41'(hs_r);
  assign bank2 = (cmd.step >= ST_BQ2_A0) && (cmd.step <= ST_BQ2_OUT);
  assign h0    = bank2 ? bq2_r[0] : bq1_r[0];
  assign h1    = bank2 ? bq2_r[1] : bq1_r[1];
  assign h2    = bank2 ? bq2_r[2] : bq1_r[2];
  assign h3    = bank2 ? bq2_r[3] : bq1_r[3];
  assign y_nxt = sat32(rnd64(acc_r - p_r, 24));

  // input to Q8.24, result back to the sample format
  always_comb begin
    raw64 = 64'(sample_in);
    if (DN > 0)      x64 = raw64 <<< DN;
    else if (UP > 0) x64 = rnd64(raw64, UP);
    else             x64 = raw64;
    x_nxt = x64[31:0];
    v64   = 64'(v_r);
    if (DN > 0) o64 = rnd64(v64, DN);
    else        o64 = v64 <<< UP;
    if (o64 > OUT_HI)      out_nxt = OUT_HI[SAMPLE_WIDTH-1:0];
    else if (o64 < OUT_LO) out_nxt = OUT_LO[SAMPLE_WIDTH-1:0];
    else                   out_nxt = o64[SAMPLE_WIDTH-1:0];
  end

  assign sample_out = out_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      ST_SEG_MUL:  begin mul_a = 34'(x_r);     mul_b = 34'(cfg.cutoff_step); end
      ST_MELT_A:   begin mul_a = 34'(seg_r);   mul_b = 34'(ONE_Q16 - cfg.meltdown_mix); end
      ST_MELT_B:   begin mul_a = 34'(x_r);     mul_b = 34'(cfg.meltdown_mix); end
      ST_PX_MUL:   begin mul_a = 34'(phase_r); mul_b = 34'(cfg.acid_trim); end
      ST_PYY_MUL:  begin mul_a = 34'(py);      mul_b = 34'(py); end
      ST_PXX_MUL:  begin mul_a = 34'(px_r);    mul_b = 34'(px_r); end
      ST_W3_MUL:   begin mul_a = 34'(pyy_r);   mul_b = 34'(py); end
      ST_W2_MUL:   begin mul_a = 34'(pyy_r);   mul_b = 34'(px_r); end
      ST_W1_MUL:   begin mul_a = 34'(pxx_r);   mul_b = 34'(py); end
      ST_W0_MUL:   begin mul_a = 34'(pxx_r);   mul_b = 34'(px_r); end
      ST_MID3:     begin mul_a = 34'(cp_r[3]); mul_b = 34'(w3_r); end
      ST_MID2:     begin mul_a = 34'(cp_r[2]); mul_b = 34'(w2_r); end
      ST_MID1:     begin mul_a = 34'(cp_r[1]); mul_b = 34'(w1_r); end
      ST_MID0:     begin mul_a = 34'(cp_r[0]); mul_b = 34'(w0_r); end
      ST_UND:      begin mul_a = 34'(mid_r);   mul_b = 34'(cfg.under_gain); end
      ST_OVR:      begin mul_a = 34'(x_r) - 34'(mid_r); mul_b = 34'(cfg.over_gain); end
      ST_TRIM:     begin mul_a = 34'(v_r);     mul_b = 34'(cfg.input_trim); end
      ST_HP_MUL:   begin
        mul_a = 34'($signed(hp_diff[40:16]));
        mul_b = 34'(cfg.highpass_rate);
      end
      ST_HP_LO:    begin
        mul_a = 34'(hp_diff[15:0]);
        mul_b = 34'(cfg.highpass_rate);
      end
      ST_BQ1_A0, ST_BQ2_A0: begin mul_a = 34'(v_r); mul_b = LP_A0; end
      ST_BQ1_A1, ST_BQ2_A1: begin mul_a = 34'(h0);  mul_b = LP_A1; end
      ST_BQ1_A2, ST_BQ2_A2: begin mul_a = 34'(h1);  mul_b = LP_A2; end
      ST_BQ1_B1, ST_BQ2_B1: begin mul_a = 34'(h2);  mul_b = LP_B1; end
      ST_BQ1_B2, ST_BQ2_B2: begin mul_a = 34'(h3);  mul_b = LP_B2; end
      ST_SQ_MUL:   begin mul_a = 34'(v_r);     mul_b = 34'(v_r); end
      ST_Q4_MUL:   begin mul_a = 34'(t_r);     mul_b = 34'(t_r); end
      ST_Q5_MUL:   begin mul_a = 34'(t_r);     mul_b = 34'(v_r); end
      ST_CLIP_MUL: begin mul_a = 34'(t_r);     mul_b = CLIP_K; end
      ST_OTRIM_MUL: begin mul_a = 34'(v_r);    mul_b = 34'(cfg.output_trim); end
      default: ;
    endcase
  end

  assign mul_prod = 64'(mul_a * mul_b);

  // persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 18'(ONE_Q16);
      seg_r   <= '0;
      hs_r    <= '0;
      wrap_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cp_r[i]  <= '0;
        bq1_r[i] <= '0;
        bq2_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      unique case (cmd.step)
        ST_SEG_MUL: phase_r <= phase_r + 18'(cfg.cutoff_step);
        ST_SEG_ACC: begin
          seg_r <= sat32(64'(seg_r) + rnd64(p_r, 16));
          if (phase_r > 18'(ONE_Q16)) begin
            phase_r <= phase_r - 18'(ONE_Q16);
            wrap_r  <= 1'b1;
          end else begin
            wrap_r  <= 1'b0;
          end
        end
        ST_MELT_PT: begin
          if (wrap_r) begin
            cp_r[3] <= cp_r[2];
            cp_r[2] <= cp_r[1];
            cp_r[1] <= cp_r[0];
            cp_r[0] <= sat32(rnd64(acc_r + p_r, 16));
            seg_r   <= '0;
          end
        end
        ST_HP_ACC: hs_r <= sat40(64'(hs_r) + rnd64(acc_r + p_r, 24));
        ST_BQ1_OUT: begin
          bq1_r[1] <= bq1_r[0];
          bq1_r[0] <= v_r;
          bq1_r[3] <= bq1_r[2];
          bq1_r[2] <= y_nxt;
        end
        ST_BQ2_OUT: begin
          bq2_r[1] <= bq2_r[0];
          bq2_r[0] <= v_r;
          bq2_r[3] <= bq2_r[2];
          bq2_r[2] <= y_nxt;
        end
        default: ;
      endcase
    end
  end

  // scratch registers and the product register
  always_ff @(posedge clk) begin
    if (cmd.load) x_r <= x_nxt;
    if (cmd.exec) begin
      p_r <= mul_prod;
      unique case (cmd.step)
        ST_MELT_B:  acc_r <= p_r;
        ST_PX:      px_r  <= 17'((p_r + 64'sd32768) >>> 16);
        ST_PXX_MUL: pyy_r <= 33'(p_r);
        ST_W3_MUL:  pxx_r <= 33'(p_r);
        ST_W2_MUL:  w3_r  <= 17'((p_r + HALF32) >>> 32);
        ST_W1_MUL:  w2_r  <= 17'(((p_r <<< 1) + p_r + HALF32) >>> 32);
        ST_W0_MUL:  w1_r  <= 17'(((p_r <<< 1) + p_r + HALF32) >>> 32);
        ST_MID3:    w0_r  <= 17'((p_r + HALF32) >>> 32);
        ST_MID2:    acc_r <= p_r;
        ST_MID1:    acc_r <= acc_r + p_r;
        ST_MID0:    acc_r <= acc_r + p_r;
        ST_MID:     mid_r <= sat32(rnd64(acc_r + p_r, 16));
        ST_OVR:     acc_r <= p_r;
        ST_MIX:     v_r   <= sat32(rnd64(acc_r + p_r, 16));
        ST_DRIVE:   v_r   <= sat32(rnd64(p_r, 16));
        ST_HP_LO:   acc_r <= p_r <<< 16;
        ST_HP_SUB:  v_r   <= sat32(64'(v_r) - rnd64(64'(hs_r), 8));
        ST_BQ1_A1, ST_BQ2_A1: acc_r <= p_r;
        ST_BQ1_A2, ST_BQ2_A2: acc_r <= acc_r + p_r;
        ST_BQ1_B1, ST_BQ2_B1: acc_r <= acc_r + p_r;
        ST_BQ1_B2, ST_BQ2_B2: acc_r <= acc_r - p_r;
        ST_BQ1_OUT, ST_BQ2_OUT: v_r <= y_nxt;
        ST_CLAMP: begin
          if (v_r > CLAMP_ONE)       v_r <= CLAMP_ONE;
          else if (v_r < -CLAMP_ONE) v_r <= -CLAMP_ONE;
        end
        ST_SQ, ST_Q4, ST_Q5: t_r <= 32'(rnd64(p_r, 24));
        ST_CLIP:    v_r   <= v_r - 32'(rnd64(p_r, 16));
        ST_OTRIM:   v_r   <= sat32(rnd64(p_r, 16));
        ST_EMIT:    out_r <= out_nxt;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/bezier_resonant_lowpass_opamp_unit.sv =====
// ----------------------------------------------------------------------------
// bezier_resonant_lowpass_opamp_unit: curve lowpass with op-amp soft clip
// Channel     | Dir | Payload                  | Handshake
// in_chan     | in  | sample_in  (signed Q1.x) | valid/ready
// out_chan    | out | sample_out (signed Q1.x) | valid/ready
// cfg_chan    | in  | index (4b), wdata (30b)  | valid/ready, ready always high
//
// Output valid rises after 51 sequencer steps around one shared 34x34
// multiplier, the highpass product taking two of them.
// The sequencer returns to idle once the result sits in the output register,
// so the next item is accepted while that result still waits, but no new
// item is accepted while the sequencer runs.
// A stalled output holds the last step until the output register frees up.
// Synchronous active-low reset restores the register defaults and clears the
// curve, highpass and biquad state; the first item then wraps the phase.
// ----------------------------------------------------------------------------
module bezier_resonant_lowpass_opamp_unit import brlo_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  brlo_in_if.sink                     in_chan,
  brlo_out_if.source                  out_chan,
  brlo_cfg_if.sink                    cfg_chan
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  // register file: writes land whenever the channel is valid
  brlo_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.wdata),
    .wr_ready (cfg_chan.ready),
    .cfg      (cfg)
  );

  // sequencer: accept, step through the datapath, raise output valid
  brlo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // datapath: all arithmetic and filter state
  brlo_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .sample_in  (in_chan.sample_in),
    .sample_out (out_chan.sample_out)
  );

endmodule

// ===== hdl/brlo_checker.sv =====
// ----------------------------------------------------------------------------
// brlo_checker: port-level assertions
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
module brlo_checker import brlo_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_data
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item in flight: no second accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // a result cannot appear in the cycle after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind bezier_resonant_lowpass_opamp_unit brlo_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_brlo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.sample_out)
);

// ===== tb/sv/tb_bezier_resonant_lowpass_opamp_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bezier_resonant_lowpass_opamp_unit: self-checking bench for the curve lowpass
// Drives samples through the unit across several register settings, predicts
// every output sample with a bit-exact model of the fixed-point chain, and
// compares each result in order while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_bezier_resonant_lowpass_opamp_unit;
  import brlo_pkg::*;

  localparam int SW = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  brlo_in_if  #(SW) in_if ();
  brlo_out_if #(SW) out_if ();
  brlo_cfg_if       cfg_if ();

  bezier_resonant_lowpass_opamp_unit #(.SAMPLE_WIDTH(SW)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // --------------------------------------------------------------------------
  // Shadow registers and filter state of the predictor
  // --------------------------------------------------------------------------
  longint r_step, r_acid, r_over, r_under, r_melt, r_itrim, r_otrim, r_hprate;
  longint phase_acc, seg_acc, hp_acc;
  longint ctrl_pt [4];
  longint bq_hist [2][4];

  logic signed [SW-1:0] pending_samples [$];
  logic signed [SW-1:0] expected_samples [$];

  int in_accepts = 0;
  int in_seen = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cfg_writes = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit no_idle = 1'b0;

  // round half up, then floor
  function automatic longint rshift_rnd(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_bits(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint limit_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void reset_model();
    r_step = RST_CUTOFF_STEP;  r_acid = RST_ACID_TRIM;     r_over = RST_OVER_GAIN;
    r_under = RST_UNDER_GAIN;  r_melt = RST_MELTDOWN_MIX;  r_itrim = RST_INPUT_TRIM;
    r_otrim = RST_OUTPUT_TRIM; r_hprate = RST_HIGHPASS_RATE;
    phase_acc = 65536;
    seg_acc = 0;
    hp_acc = 0;
    for (int i = 0; i < 4; i++) begin
      ctrl_pt[i] = 0;
      bq_hist[0][i] = 0;
      bq_hist[1][i] = 0;
    end
  endfunction

  // register write as the unit sees it: masked to the register width
  function automatic void apply_reg(logic [3:0] idx, logic [29:0] d);
    case (idx)
      REG_CUTOFF_STEP:   r_step   = d[16:0];
      REG_ACID_TRIM:     r_acid   = d[16:0];
      REG_OVER_GAIN:     r_over   = d[16:0];
      REG_UNDER_GAIN:    r_under  = d[16:0];
      REG_MELTDOWN_MIX:  r_melt   = d[16:0];
      REG_INPUT_TRIM:    r_itrim  = d;
      REG_OUTPUT_TRIM:   r_otrim  = d[16:0];
      REG_HIGHPASS_RATE: r_hprate = d[15:0];
      default: ;
    endcase
  endfunction

  function automatic longint lowpass_biquad(int k, longint xin);
    longint acc, y;
    acc = LP_A0 * xin + LP_A1 * bq_hist[k][0] + LP_A2 * bq_hist[k][1]
        - LP_B1 * bq_hist[k][2] - LP_B2 * bq_hist[k][3];
    y = clip_bits(rshift_rnd(acc, 24), 32);
    bq_hist[k][1] = bq_hist[k][0]; bq_hist[k][0] = xin;
    bq_hist[k][3] = bq_hist[k][2]; bq_hist[k][2] = y;
    return y;
  endfunction

  function automatic logic signed [SW-1:0] shape_sample(logic signed [SW-1:0] s);
    longint stp, acid, ovr, und, melt, itrim, otrim;
    longint x, px, py, w0, w1, w2, w3, mid, v, sq, q4, q5, o;
    stp   = limit_to(r_step, 7, 65536);
    acid  = limit_to(r_acid, 0, 65536);
    ovr   = limit_to(r_over, 0, 65536);
    und   = limit_to(r_under, 0, 65536);
    melt  = limit_to(r_melt, 0, 65536);
    itrim = limit_to(r_itrim, 0, 655360000);
    otrim = limit_to(r_otrim, 0, 65536);
    x = longint'(s) * 2;  // Q1.23 to Q8.24

    phase_acc += stp;
    seg_acc = clip_bits(seg_acc + rshift_rnd(x * stp, 16), 32);
    if (phase_acc > 65536) begin
      phase_acc -= 65536;
      ctrl_pt[3] = ctrl_pt[2];
      ctrl_pt[2] = ctrl_pt[1];
      ctrl_pt[1] = ctrl_pt[0];
      ctrl_pt[0] = clip_bits(rshift_rnd(seg_acc * (65536 - melt) + x * melt, 16), 32);
      seg_acc = 0;
    end

    px = (phase_acc * acid + 32768) >> 16;
    py = 65536 - px;
    w3 = (py * py * py + 64'h80000000) >> 32;
    w2 = (3 * py * py * px + 64'h80000000) >> 32;
    w1 = (3 * py * px * px + 64'h80000000) >> 32;
    w0 = (px * px * px + 64'h80000000) >> 32;
    mid = clip_bits(rshift_rnd(ctrl_pt[3] * w3 + ctrl_pt[2] * w2
                               + ctrl_pt[1] * w1 + ctrl_pt[0] * w0, 16), 32);

    v = clip_bits(rshift_rnd(mid * und + (x - mid) * ovr, 16), 32);
    v = clip_bits(rshift_rnd(v * itrim, 16), 32);

    hp_acc = clip_bits(hp_acc + rshift_rnd((v * 256 - hp_acc) * r_hprate, 24), 40);
    v = clip_bits(v - rshift_rnd(hp_acc, 8), 32);

    v = lowpass_biquad(0, v);
    if (v > (64'sd1 <<< 24)) v = 64'sd1 <<< 24;
    if (v < -(64'sd1 <<< 24)) v = -(64'sd1 <<< 24);
    sq = rshift_rnd(v * v, 24);
    q4 = rshift_rnd(sq * sq, 24);
    q5 = rshift_rnd(q4 * v, 24);
    v = v - rshift_rnd(q5 * CLIP_K, 16);
    v = lowpass_biquad(1, v);
    v = clip_bits(rshift_rnd(v * otrim, 16), 32);

    o = clip_bits(rshift_rnd(v, 1), SW);
    return o[SW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: track register writes, predict on input accept, check on output
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic signed [SW-1:0] want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        apply_reg(cfg_if.index, cfg_if.wdata);
        cfg_writes++;
      end
      if (in_if.valid && in_if.ready) begin
        expected_samples.push_back(shape_sample(in_if.sample_in));
        in_accepts++;
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d with nothing pending", out_if.sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (out_if.sample_out !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: sample_out expected %0d got %0d",
                       results_seen, want, out_if.sample_out);
          end
        end
      end
    end
  end

  // mostly no gap, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: feed pending items at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    logic nv;
    nv = in_if.valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      // drop the item the last rising edge took
      if (in_if.valid && in_accepts != in_seen) begin
        in_seen = in_accepts;
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_samples.size() > 0) begin
          in_if.sample_in <= pending_samples.pop_front();
          nv = 1'b1;
          in_gap = pick_gap();
        end
      end
    end
    in_if.valid <= nv;
  end

  // Receiver: stall the output at random
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_stall = pick_gap();
      out_if.ready <= (out_stall == 0);
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [29:0] d);
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.wdata <= d;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // hold until every item is through, then let the sequencer settle
  task automatic drain();
    while (pending_samples.size() > 0 || expected_samples.size() > 0 || in_if.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [29:0] pick_value(int idx);
    int r;
    r = $urandom_range(9);
    if (idx == REG_INPUT_TRIM) begin
      case (r)
        0: return 30'd0;
        1: return ITRIM_MAX;
        2: return 30'h3FFFFFFF;
        3, 4, 5: return 30'($urandom_range(200000));
        default: return 30'($urandom_range(3000000));
      endcase
    end
    case (r)
      0: return 30'd0;
      1: return (idx == REG_HIGHPASS_RATE) ? 30'd65535 : 30'd65536;
      2: return 30'($urandom());
      3: return 30'd7;
      default: return 30'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_sample(ref longint walk);
    int r;
    r = $urandom_range(99);
    if (r < 40) return SW'($urandom());
    if (r < 50) return r[0] ? 24'sh7FFFFF : 24'sh800000;
    if (r < 55) return SW'($urandom_range(3) - 2);
    walk = clip_bits(walk + $signed($urandom_range(400000)) - 200000, 24);
    return walk[SW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    longint walk;
    int phase_items;
    walk = 0;
    reset_model();
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: first item wraps, the next lands on phase exactly one
    no_idle = 1'b1;
    pending_samples.push_back(24'sh7FFFFF);
    pending_samples.push_back(24'sh7FFFFF);
    pending_samples.push_back(24'sh800000);
    pending_samples.push_back(24'sd0);
    pending_samples.push_back(24'sd1);
    pending_samples.push_back(-24'sd1);
    pending_samples.push_back(24'sh555555);
    pending_samples.push_back(24'shAAAAAA);
    drain();

    // heavy drive into the clip, full step, out-of-range gains, index above seven
    write_reg(REG_CUTOFF_STEP, 30'd65536);
    write_reg(REG_INPUT_TRIM, 30'h3FFFFFFF);
    write_reg(REG_OVER_GAIN, 30'h1FFFF);
    write_reg(REG_MELTDOWN_MIX, 30'h3FFFFFFF);
    write_reg(REG_ACID_TRIM, 30'h1FFFF);
    write_reg(REG_OUTPUT_TRIM, 30'h1FFFF);
    write_reg(REG_HIGHPASS_RATE, 30'hFFFF);
    write_reg(4'd9, 30'd12345);
    write_reg(4'd15, 30'h3FFFFFFF);
    no_idle = 1'b0;
    for (int i = 0; i < 8; i++)
      pending_samples.push_back(i[0] ? 24'sh7FFFFF : 24'sh800000);
    drain();

    // step below the floor, zero under gain, trims and highpass rate
    write_reg(REG_CUTOFF_STEP, 30'd0);
    write_reg(REG_UNDER_GAIN, 30'd0);
    write_reg(REG_INPUT_TRIM, 30'd0);
    write_reg(REG_HIGHPASS_RATE, 30'd0);
    write_reg(REG_OUTPUT_TRIM, 30'd0);
    write_reg(REG_ACID_TRIM, 30'd0);
    for (int i = 0; i < 4; i++) pending_samples.push_back(SW'($urandom()));
    drain();

    // random phases under fresh settings
    for (int p = 0; p < 8; p++) begin
      for (int k = 0; k < 8; k++)
        if ($urandom_range(2) != 0 || p == 0) write_reg(k[3:0], pick_value(k));
      if ($urandom_range(3) == 0) write_reg(4'($urandom_range(15, 8)), 30'($urandom()));
      no_idle = ($urandom_range(3) == 0);
      phase_items = $urandom_range(110, 65);
      for (int i = 0; i < phase_items; i++)
        pending_samples.push_back(pick_sample(walk));
      drain();
    end

    $display("covered %0d samples and %0d register writes over 11 settings",
             in_accepts, cfg_writes);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #30000000;
    $display("timeout with %0d results outstanding", expected_samples.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
